// ===== rtl/core/sed_pkg.sv =====
// ----------------------------------------------------------------------------
// sed_pkg
// shared types and constants for the string escape decoder
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [4:0] ErrHexit      = 5'b00001;
  localparam logic [4:0] ErrBrace      = 5'b00010;
  localparam logic [4:0] ErrCodepoint  = 5'b00100;
  localparam logic [4:0] ErrCloseBrace = 5'b01000;
  localparam logic [4:0] ErrEscape     = 5'b10000;

  // decoded work for one input word: up to four bytes then an optional end word
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    logic            eos;
    logic [4:0]      flags;
  } job_t;

endpackage

// ===== rtl/core/string_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// string_escape_decoder
// decodes escapes of a quoted string literal body into output bytes
// ----------------------------------------------------------------------------
// a taken input word's job is written into the job queue, and the back part then
// loads its first output word into the output register
// throughput: one input word per cycle; a job of up to five output words drains
// one output word at a time while the sink is ready, and the input
// stalls while the four-entry job queue is full
// reset: all control state cleared, decoder back in normal character mode
// ----------------------------------------------------------------------------
module string_escape_decoder
  import sed_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // out_byte, error_flags, zero fill
  output logic [1:0]  m_axis_tuser,   // has_byte, end_of_string
  output logic        m_axis_tlast    // last_of_run
);

  logic accept, push, pop, empty, full;
  job_t push_job, head;
  logic [7:0] out_byte;
  logic [4:0] out_flags;
  logic out_has, out_eos;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  sed_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .char_i  (s_axis_tdata),
    .push_o  (push),
    .job_o   (push_job)
  );

  sed_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .pop_i     (pop),
    .head_o    (head),
    .empty_o   (empty),
    .full_o    (full)
  );

  sed_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .empty_i(empty),
    .pop_o  (pop),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .byte_o (out_byte),
    .has_o  (out_has),
    .flags_o(out_flags),
    .eos_o  (out_eos),
    .last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_flags, out_byte};
  assign m_axis_tuser = {out_eos, out_has};

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full))
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && empty))
    else $error("job popped from an empty queue");

  a_eos_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && !m_axis_tuser[0]))
    else $error("end word not last of run or carries a byte");

  a_flags_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[12:8] == 5'b0))
    else $error("error flags on a word that is not last of run");

endmodule

// ===== rtl/core/sed_front.sv =====
// ----------------------------------------------------------------------------
// sed_front
// escape state machine: classifies each input byte and builds a job
// ----------------------------------------------------------------------------
module sed_front
  import sed_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] char_i,
  output logic       push_o,
  output job_t       job_o
);

  typedef enum logic [5:0] {
    ModeNormal = 6'b000001,
    ModeEsc    = 6'b000010,
    ModeHex2   = 6'b000100,
    ModeUBrace = 6'b001000,
    ModeUHex   = 6'b010000,
    ModeUHexNb = 6'b100000
  } mode_e;

  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChApos   = 8'h27;
  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChU      = 8'h75;

  localparam logic [24:0] CpLimit   = 25'h110000;
  localparam logic [20:0] CpReplace = 21'h1F642;
  localparam logic [20:0] SurLo     = 21'h00D800;
  localparam logic [20:0] SurHi     = 21'h00DFFF;

  mode_e       mode_q, mode_d;
  logic [3:0]  nib_q, nib_d;
  logic [20:0] acc_q, acc_d;
  logic        big_q, big_d;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [24:0] acc_next;
  logic [20:0] cp;
  job_t        job;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = '0;
    if (char_i >= 8'h30 && char_i <= 8'h39) begin
      hex_val = char_i[3:0];
    end else if ((char_i >= 8'h61 && char_i <= 8'h66) ||
                 (char_i >= 8'h41 && char_i <= 8'h46)) begin
      hex_val = char_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign acc_next = {acc_q, hex_val};

  always_comb begin
    mode_d = mode_q;
    nib_d  = nib_q;
    acc_d  = acc_q;
    big_d  = big_q;
    job    = '0;
    cp     = acc_q;
    unique case (mode_q)
      ModeEsc: begin
        if (hex_ok) begin
          nib_d  = hex_val;
          mode_d = ModeHex2;
        end else begin
          mode_d     = ModeNormal;
          job.nbytes = 3'd1;
          case (char_i)
            ChT:      job.bytes[0] = 8'h09;
            ChN:      job.bytes[0] = 8'h0A;
            ChR:      job.bytes[0] = 8'h0D;
            ChQuote, ChApos, ChBslash: job.bytes[0] = char_i;
            ChU: begin
              job.nbytes = 3'd0;
              acc_d      = '0;
              big_d      = 1'b0;
              mode_d     = ModeUBrace;
            end
            default: begin
              job.bytes[0] = ChBslash;
              job.flags    = ErrEscape;
            end
          endcase
        end
      end
      ModeHex2: begin
        mode_d = ModeNormal;
        if (hex_ok) begin
          job.bytes[0] = {nib_q, hex_val};
          job.nbytes   = 3'd1;
        end else begin
          job.bytes[0] = {nib_q, 4'h0};
          job.nbytes   = 3'd1;
          job.flags    = ErrHexit;
          if (char_i == ChBslash) begin
            mode_d = ModeEsc;
          end else if (char_i == ChQuote) begin
            job.eos = 1'b1;
          end else begin
            job.bytes[1] = char_i;
            job.nbytes   = 3'd2;
          end
        end
      end
      ModeUBrace: begin
        if (char_i == ChQuote) begin
          job.flags = ErrBrace | ErrCloseBrace;
          job.eos   = 1'b1;
          mode_d    = ModeNormal;
        end else if (char_i == ChLBrace) begin
          mode_d = ModeUHex;
        end else begin
          mode_d = ModeUHexNb;
        end
      end
      ModeUHex, ModeUHexNb: begin
        if (hex_ok) begin
          if (!big_q) begin
            if (acc_next >= CpLimit) begin
              big_d = 1'b1;
            end else begin
              acc_d = acc_next[20:0];
            end
          end
        end else begin
          if (mode_q == ModeUHexNb) begin
            job.flags = job.flags | ErrBrace;
          end
          if (big_q || ({4'b0, acc_q} >= CpLimit) || (acc_q >= SurLo && acc_q <= SurHi)) begin
            job.flags = job.flags | ErrCodepoint;
            cp        = CpReplace;
          end
          if (cp < 21'h80) begin
            job.bytes[0] = cp[7:0];
            job.nbytes   = 3'd1;
          end else if (cp < 21'h800) begin
            job.bytes[0] = {3'b110, cp[10:6]};
            job.bytes[1] = {2'b10, cp[5:0]};
            job.nbytes   = 3'd2;
          end else if (cp < 21'h10000) begin
            job.bytes[0] = {4'b1110, cp[15:12]};
            job.bytes[1] = {2'b10, cp[11:6]};
            job.bytes[2] = {2'b10, cp[5:0]};
            job.nbytes   = 3'd3;
          end else begin
            job.bytes[0] = {5'b11110, cp[20:18]};
            job.bytes[1] = {2'b10, cp[17:12]};
            job.bytes[2] = {2'b10, cp[11:6]};
            job.bytes[3] = {2'b10, cp[5:0]};
            job.nbytes   = 3'd4;
          end
          if (char_i != ChRBrace) begin
            job.flags = job.flags | ErrCloseBrace;
          end
          job.eos = (char_i == ChQuote);
          mode_d  = ModeNormal;
          acc_d   = '0;
          big_d   = 1'b0;
        end
      end
      default: begin
        mode_d = ModeNormal;
        if (char_i == ChBslash) begin
          mode_d = ModeEsc;
        end else if (char_i == ChQuote) begin
          job.eos = 1'b1;
        end else begin
          job.bytes[0] = char_i;
          job.nbytes   = 3'd1;
        end
      end
    endcase
  end

  assign push_o = accept_i && ((job.nbytes != 3'd0) || job.eos);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      nib_q  <= '0;
      acc_q  <= '0;
      big_q  <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      nib_q  <= nib_d;
      acc_q  <= acc_d;
      big_q  <= big_d;
    end
  end

endmodule

// ===== rtl/core/sed_fifo.sv =====
// ----------------------------------------------------------------------------
// sed_fifo
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
module sed_fifo
  import sed_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic empty_o,
  output logic full_o
);

  job_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wptr_q, rptr_q;
  logic [FifoCntW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/sed_back.sv =====
// ----------------------------------------------------------------------------
// sed_back
// expands queued jobs into output words through an output register
// ----------------------------------------------------------------------------
module sed_back
  import sed_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  job_t        head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [7:0]  byte_o,
  output logic        has_o,
  output logic [4:0]  flags_o,
  output logic        eos_o,
  output logic        last_o
);

  logic [2:0] idx_q;
  logic       valid_q;
  logic [7:0] byte_q;
  logic       has_q, eos_q, last_q;
  logic [4:0] flags_q;

  logic [2:0] total;
  logic       load, is_last, is_byte;

  assign total   = head_i.nbytes + {2'b0, head_i.eos};
  assign is_last = (idx_q == total - 3'd1);
  assign is_byte = (idx_q < head_i.nbytes);
  assign load    = !empty_i && (!valid_q || ready_i);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= is_byte ? head_i.bytes[idx_q[1:0]] : 8'h00;
      has_q   <= is_byte;
      eos_q   <= !is_byte;
      last_q  <= is_last;
      flags_q <= is_last ? head_i.flags : 5'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 3'd0 : idx_q + 3'd1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign has_o   = has_q;
  assign flags_o = flags_q;
  assign eos_o   = eos_q;
  assign last_o  = last_q;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the string escape decoder: directed literal
// bodies, then random ones; typed rows are checked against their table word,
// other words against a behavioural decoder; random idling on both stream sides
// ----------------------------------------------------------------------------
module testbench
  import sed_pkg::*;
();

  localparam int unsigned CycleLimit = 200000;
  localparam logic [7:0]  ChBslash   = 8'h5C;
  localparam logic [7:0]  ChQuote    = 8'h22;
  localparam logic [7:0]  ChApos     = 8'h27;
  localparam logic [7:0]  ChLbrace   = 8'h7B;
  localparam logic [7:0]  ChRbrace   = 8'h7D;
  localparam logic [24:0] CpLimit    = 25'h110000;
  localparam logic [20:0] CpReplace  = 21'h1F642;
  localparam logic [20:0] SurrLo     = 21'h00D800;
  localparam logic [20:0] SurrHi     = 21'h00DFFF;

  typedef enum logic [2:0] {
    ModeText, ModeEscape, ModeHexLow, ModeUBrace, ModeURun, ModeURunNoBrace
  } dec_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic [4:0] flags;
    logic       eos;
    logic       last;
  } dec_word_t;

  typedef struct {
    logic [7:0] ch;
    bit         typed;
    dec_word_t  want;
  } text_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  dec_mode_e   dec_mode;
  logic [3:0]  nibble_hi;
  logic [20:0] cp_acc;
  logic        cp_big;

  dec_word_t   step_words[$];
  dec_word_t   decoded_words[$];
  text_row_t   text_rows[$];
  int unsigned errors;
  int unsigned cycle_count;
  bit          calm;

  string_escape_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic int hexit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 10) return "0" + 8'(v);
    return (upper ? "A" : "a") + 8'(v) - 8'd10;
  endfunction

  function automatic void emit(input logic [7:0] b, input logic h, input logic e);
    dec_word_t w;
    w = '{data: b, has: h, flags: 5'd0, eos: e, last: 1'b0};
    step_words.insert(step_words.size(), w);
  endfunction

  function automatic void text_char(input logic [7:0] c);
    dec_mode = ModeText;
    if (c == ChBslash) dec_mode = ModeEscape;
    else if (c == ChQuote) emit(8'h00, 1'b0, 1'b1);
    else emit(c, 1'b1, 1'b0);
  endfunction

  function automatic void emit_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      emit(cp[7:0], 1'b1, 1'b0);
    end else if (cp < 21'h800) begin
      emit({3'b110, cp[10:6]}, 1'b1, 1'b0);
      emit({2'b10, cp[5:0]}, 1'b1, 1'b0);
    end else if (cp < 21'h10000) begin
      emit({4'b1110, cp[15:12]}, 1'b1, 1'b0);
      emit({2'b10, cp[11:6]}, 1'b1, 1'b0);
      emit({2'b10, cp[5:0]}, 1'b1, 1'b0);
    end else begin
      emit({5'b11110, cp[20:18]}, 1'b1, 1'b0);
      emit({2'b10, cp[17:12]}, 1'b1, 1'b0);
      emit({2'b10, cp[11:6]}, 1'b1, 1'b0);
      emit({2'b10, cp[5:0]}, 1'b1, 1'b0);
    end
  endfunction

  // decodes one raw byte into step_words, advancing the decoder state
  function automatic void decode_char(input logic [7:0] c);
    int          h;
    logic [3:0]  h4;
    logic [4:0]  fl;
    logic [20:0] cp;
    logic [24:0] nxt;
    dec_word_t   tail;
    h  = hexit(c);
    h4 = h[3:0];
    fl = '0;
    step_words.delete();
    case (dec_mode)
      ModeEscape: begin
        if (h >= 0) begin
          nibble_hi = h4;
          dec_mode  = ModeHexLow;
        end else begin
          dec_mode = ModeText;
          if (c == "t") emit(8'h09, 1'b1, 1'b0);
          else if (c == "n") emit(8'h0A, 1'b1, 1'b0);
          else if (c == "r") emit(8'h0D, 1'b1, 1'b0);
          else if (c == ChQuote || c == ChApos || c == ChBslash) emit(c, 1'b1, 1'b0);
          else if (c == "u") begin
            cp_acc   = '0;
            cp_big   = 1'b0;
            dec_mode = ModeUBrace;
          end else begin
            emit(ChBslash, 1'b1, 1'b0);
            fl |= ErrEscape;
          end
        end
      end
      ModeHexLow: begin
        dec_mode = ModeText;
        if (h >= 0) begin
          emit({nibble_hi, h4}, 1'b1, 1'b0);
        end else begin
          emit({nibble_hi, 4'h0}, 1'b1, 1'b0);
          fl |= ErrHexit;
          text_char(c);
        end
      end
      ModeUBrace: begin
        if (c == ChQuote) begin
          fl |= ErrBrace | ErrCloseBrace;
          emit(8'h00, 1'b0, 1'b1);
          dec_mode = ModeText;
        end else begin
          dec_mode = (c == ChLbrace) ? ModeURun : ModeURunNoBrace;
        end
      end
      ModeURun, ModeURunNoBrace: begin
        if (h >= 0) begin
          if (!cp_big) begin
            nxt = {cp_acc, h4};
            if (nxt >= CpLimit) cp_big = 1'b1;
            else cp_acc = nxt[20:0];
          end
        end else begin
          cp = cp_acc;
          if (dec_mode == ModeURunNoBrace) fl |= ErrBrace;
          if (cp_big || 25'(cp) >= CpLimit || (cp >= SurrLo && cp <= SurrHi)) begin
            fl |= ErrCodepoint;
            cp = CpReplace;
          end
          emit_utf8(cp);
          if (c != ChRbrace) fl |= ErrCloseBrace;
          if (c == ChQuote) emit(8'h00, 1'b0, 1'b1);
          dec_mode = ModeText;
          cp_acc   = '0;
          cp_big   = 1'b0;
        end
      end
      default: text_char(c);
    endcase
    if (step_words.size() > 0) begin
      tail       = step_words.pop_back();
      tail.flags = fl;
      tail.last  = 1'b1;
      step_words.insert(step_words.size(), tail);
    end
  endfunction

  function automatic dec_word_t word_of(input logic [7:0] b, input logic h,
                                        input logic [4:0] f, input logic e);
    return '{data: b, has: h, flags: f, eos: e, last: 1'b1};
  endfunction

  function automatic void add_row(input logic [7:0] c, input bit typed,
                                  input dec_word_t want);
    text_row_t row;
    row = '{ch: c, typed: typed, want: want};
    text_rows.insert(text_rows.size(), row);
  endfunction

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[string_escape_decoder] ERROR");
      $finish;
    end
  end

  // output word checker
  always @(posedge clk_i) begin : word_check
    dec_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decoded_words.size() == 0) begin
        $display("%0t ns: unexpected word, expected none, actual tdata=%h tuser=%b tlast=%b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        want = decoded_words.pop_front();
        check_field("out_byte", want.data, m_axis_tdata[7:0]);
        check_field("error_flags", 8'(want.flags), 8'(m_axis_tdata[12:8]));
        check_field("zero fill", 8'h00, 8'(m_axis_tdata[15:13]));
        check_field("has_byte", 8'(want.has), 8'(m_axis_tuser[0]));
        check_field("end_of_string", 8'(want.eos), 8'(m_axis_tuser[1]));
        check_field("last_of_run", 8'(want.last), 8'(m_axis_tlast));
      end
    end
  end

  // output side stalls
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        m_axis_tready <= 1'b0;
        @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // stimulus and end of run
  initial begin
    text_row_t   r;
    logic [7:0]  c;
    logic [7:0]  simple_esc[6];
    logic [31:0] cp;
    int          ndig;
    int          k;
    int unsigned cat;
    int unsigned gap;
    int unsigned directed_len;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    calm          = 1'b0;
    errors        = 0;
    cycle_count   = 0;
    dec_mode      = ModeText;
    nibble_hi     = '0;
    cp_acc        = '0;
    cp_big        = 1'b0;
    simple_esc    = '{"t", "n", "r", ChQuote, ChApos, ChBslash};

    // directed literal bodies
    add_row("A",      1'b1, word_of(8'h41, 1'b1, 5'd0, 1'b0));
    add_row(8'hFF,    1'b1, word_of(8'hFF, 1'b1, 5'd0, 1'b0));
    add_row(8'h00,    1'b1, word_of(8'h00, 1'b1, 5'd0, 1'b0));
    add_row(ChQuote,  1'b1, word_of(8'h00, 1'b0, 5'd0, 1'b1));
    add_row(ChBslash, 1'b0, '0);
    add_row("n",      1'b1, word_of(8'h0A, 1'b1, 5'd0, 1'b0));
    add_row(ChBslash, 1'b0, '0);
    add_row("a",      1'b0, '0);
    add_row("B",      1'b0, '0);
    // second hex digit missing, the quote then ends the string
    add_row(ChBslash, 1'b0, '0);
    add_row("7",      1'b0, '0);
    add_row(ChQuote,  1'b0, '0);
    add_row(ChBslash, 1'b0, '0);
    add_row("q",      1'b1, word_of(ChBslash, 1'b1, ErrEscape, 1'b0));
    // quote where the opening brace belongs
    add_row(ChBslash, 1'b0, '0);
    add_row("u",      1'b0, '0);
    add_row(ChQuote,  1'b1, word_of(8'h00, 1'b0, ErrBrace | ErrCloseBrace, 1'b1));
    // empty hex run
    add_row(ChBslash, 1'b0, '0);
    add_row("u",      1'b0, '0);
    add_row(ChLbrace, 1'b0, '0);
    add_row(ChRbrace, 1'b1, word_of(8'h00, 1'b1, 5'd0, 1'b0));
    // no brace, run ended by a quote
    add_row(ChBslash, 1'b0, '0);
    add_row("u",      1'b0, '0);
    add_row("x",      1'b0, '0);
    add_row("D",      1'b0, '0);
    add_row("8",      1'b0, '0);
    add_row(ChQuote,  1'b0, '0);
    directed_len = text_rows.size();

    // random literal bodies
    while (text_rows.size() < directed_len + 450) begin
      cat = $urandom_range(0, 99);
      if (cat < 20) begin
        repeat ($urandom_range(1, 3)) begin
          c = 8'($urandom_range(32, 126));
          while (c == ChBslash || c == ChQuote) c = 8'($urandom_range(32, 126));
          add_row(c, 1'b0, '0);
        end
      end else if (cat < 28) begin
        add_row(8'($urandom_range(0, 255)), 1'b0, '0);
      end else if (cat < 40) begin
        add_row(ChBslash, 1'b0, '0);
        add_row(simple_esc[$urandom_range(0, 5)], 1'b0, '0);
      end else if (cat < 52) begin
        add_row(ChBslash, 1'b0, '0);
        add_row(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0, '0);
        if ($urandom_range(0, 4) != 0)
          add_row(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))), 1'b0, '0);
        else
          add_row(8'($urandom_range(0, 255)), 1'b0, '0);
      end else if (cat < 80) begin
        add_row(ChBslash, 1'b0, '0);
        add_row("u", 1'b0, '0);
        k = $urandom_range(0, 99);
        if (k < 7) begin
          add_row(ChQuote, 1'b0, '0);
        end else begin
          add_row((k < 92) ? ChLbrace : 8'($urandom_range(0, 255)), 1'b0, '0);
          cat = $urandom_range(0, 7);
          case (cat)
            0: cp = $urandom_range(0, 'h7F);
            1: cp = $urandom_range('h80, 'h7FF);
            2: cp = $urandom_range('h800, 'hFFFF);
            3: cp = $urandom_range('h10000, 'h10FFFF);
            4: cp = $urandom_range('hD800, 'hDFFF);
            5: cp = $urandom_range('h110000, 'hFFFFFF);
            6: cp = 0;
            default: cp = $urandom();
          endcase
          ndig = 1;
          while (ndig < 8 && (cp >> (4 * ndig)) != 0) ndig++;
          if (cat == 6) ndig = 0;
          else if (cat == 7) ndig = 8;
          ndig += $urandom_range(0, 2);
          for (k = ndig - 1; k >= 0; k--)
            add_row(hex_char(4'(cp >> (4 * k)), 1'($urandom_range(0, 1))), 1'b0, '0);
          k = $urandom_range(0, 9);
          if (k < 8) add_row(ChRbrace, 1'b0, '0);
          else if (k == 8) add_row(ChQuote, 1'b0, '0);
          else add_row(8'($urandom_range(0, 255)), 1'b0, '0);
        end
      end else if (cat < 88) begin
        add_row(ChBslash, 1'b0, '0);
        add_row(8'($urandom_range(0, 255)), 1'b0, '0);
      end else begin
        add_row(ChQuote, 1'b0, '0);
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    while (text_rows.size() != 0) begin
      r = text_rows.pop_front();
      if ($urandom_range(0, 47) == 0) calm = ~calm;
      gap = calm ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= r.ch;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      decode_char(r.ch);
      if (r.typed) decoded_words.insert(decoded_words.size(), r.want);
      else foreach (step_words[i]) decoded_words.insert(decoded_words.size(), step_words[i]);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b0;

    while (decoded_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("[string_escape_decoder] OK");
    end else begin
      $display("[string_escape_decoder] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sed_pkg.sv
rtl/core/sed_front.sv
rtl/core/sed_fifo.sv
rtl/core/sed_back.sv
rtl/core/string_escape_decoder.sv
tb/sv/testbench.sv
